// ----- hw/rtl/fpa_pkg.sv -----
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and constants of the fixed-partition allocator: register
// indexes, policy codes, field widths and the controller/datapath interface.
// ----------------------------------------------------------------------------
package fpa_pkg;

	// Default geometry handed to the top level parameters.
	localparam int DEF_PARTS     = 4;
	localparam int DEF_SIZE_BITS = 16;

	// Fixed field widths of the stream and configuration ports.
	localparam int REQ_W       = 16;
	localparam int PNUM_W      = 3;
	localparam int OUT_WASTE_W = 16;
	localparam int TOTAL_W     = 18;
	localparam int S_TDATA_W   = 16;
	localparam int M_TDATA_W   = 40;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int POLICY_W    = 2;
	localparam int PCOUNT_W    = 3;
	localparam int SIZE_REGS   = 4;

	localparam logic [PCOUNT_W-1:0] PCOUNT_RST = 3'd4;
	localparam logic [TOTAL_W-1:0]  TOTAL_MAX  = '1;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_POLICY,
		CFG_PART_COUNT,
		CFG_SIZE_0,
		CFG_SIZE_1,
		CFG_SIZE_2,
		CFG_SIZE_3
	} cfg_idx_t;

	// Placement policies.
	typedef enum logic [POLICY_W-1:0] {
		POL_FIRST,
		POL_NEXT,
		POL_BEST,
		POL_WORST
	} policy_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic start;   // latch the accepted request and set up the scan
		logic step;    // examine one partition
		logic commit;  // update state and load the result register
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic skip;       // clear request, or no active partitions: no scan
		logic scan_last;  // the partition examined now is the last one
	} status_t;

endpackage

// ----- hw/rtl/fixed_partition_allocator.sv -----
// ----------------------------------------------------------------------------
// fixed_partition_allocator
// Places memory requests into fixed partitions by first, next, best or worst
// fit and reports grant, partition number, waste and running waste total.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake            Contents
// s_*       in         s_tvalid/s_tready    s_tuser kind, s_tdata request_size
// m_*       out        m_tvalid/m_tready    m_tuser granted, m_tdata result
// cfg_*     in         cfg_we               cfg_index register, cfg_data value
//
// An allocate request is accepted, then scanned, then committed. In the scan
// the single size comparator and waste subtractor examine the active
// partitions, part_count capped at PARTS, one at a time; the commit uses the
// waste adder and waits while the output register holds a result not yet taken.
// A clear request, or any request with no active partitions, examines no
// partition.
// Reset clears all busy marks, the next-fit pointer and the waste total at
// once; there is no clearing pass. A finished result waits in the output
// register while the next request is accepted and scanned; only the commit
// waits for that register to empty.
//
// Register indexes: 0 policy, 1 part_count, 2 to 5 the sizes of partitions
// one to four. Writes to other indexes are ignored, as are size registers for
// partitions that are not built.
module fixed_partition_allocator #(
	parameter int PARTS     = fpa_pkg::DEF_PARTS,
	parameter int SIZE_BITS = fpa_pkg::DEF_SIZE_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration write port.
	input  logic                            cfg_we,
	input  logic [fpa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fpa_pkg::CFG_DATA_W-1:0]  cfg_data,
	// Request stream.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [fpa_pkg::S_TDATA_W-1:0]   s_tdata,   // [15:0] request_size
	input  logic                            s_tuser,   // [0] kind (1 frees all)
	// Result stream.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [fpa_pkg::M_TDATA_W-1:0]   m_tdata,   // [2:0] partition_number,
	                                                   // [18:3] waste,
	                                                   // [36:19] total_waste,
	                                                   // [39:37] zero
	output logic                            m_tuser    // [0] granted
);
	import fpa_pkg::*;

	cmd_t                    cmd;
	status_t                 status;
	logic [PNUM_W-1:0]       res_pnum;
	logic [OUT_WASTE_W-1:0]  res_waste;
	logic [TOTAL_W-1:0]      res_total;

	// The controller only sequences; all state that the results depend on
	// lives in the datapath.
	fpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	fpa_datapath #(
		.PARTS     (PARTS),
		.SIZE_BITS (SIZE_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req_size    (s_tdata[REQ_W-1:0]),
		.req_kind    (s_tuser),
		.cmd         (cmd),
		.status      (status),
		.res_granted (m_tuser),
		.res_pnum    (res_pnum),
		.res_waste   (res_waste),
		.res_total   (res_total)
	);

	// Result fields packed from the lowest bit up, zero padded to whole bytes.
	assign m_tdata = M_TDATA_W'({res_total, res_waste, res_pnum});

endmodule

// ----- hw/rtl/fpa_datapath.sv -----
// ----------------------------------------------------------------------------
// fpa_datapath
// Configuration registers, busy marks, next-fit pointer, running waste total
// and the one-partition-per-cycle scan unit with its result register.
// ----------------------------------------------------------------------------
module fpa_datapath #(
	parameter int PARTS     = fpa_pkg::DEF_PARTS,
	parameter int SIZE_BITS = fpa_pkg::DEF_SIZE_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [fpa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fpa_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [fpa_pkg::REQ_W-1:0]         req_size,
	input  logic                              req_kind,
	input  fpa_pkg::cmd_t                     cmd,
	output fpa_pkg::status_t                  status,
	output logic                              res_granted,
	output logic [fpa_pkg::PNUM_W-1:0]        res_pnum,
	output logic [fpa_pkg::OUT_WASTE_W-1:0]   res_waste,
	output logic [fpa_pkg::TOTAL_W-1:0]       res_total
);
	import fpa_pkg::*;

	localparam int IDX_W = (PARTS > 1) ? $clog2(PARTS) : 1;
	localparam int CNT_W = $clog2(PARTS + 1);
	localparam int SUM_W = ((SIZE_BITS > TOTAL_W) ? SIZE_BITS : TOTAL_W) + 1;
	localparam int PN_W  = IDX_W + 1;

	policy_t               policy_q;
	logic [PCOUNT_W-1:0]   pcount_q;
	logic [SIZE_BITS-1:0]  size_q [PARTS];
	logic [PARTS-1:0]      busy_q;
	logic [IDX_W-1:0]      ptr_q;
	logic [TOTAL_W-1:0]    sum_q;

	logic                  kind_q;
	logic [SIZE_BITS-1:0]  req_q;
	logic [IDX_W-1:0]      k_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  found_q;
	logic [IDX_W-1:0]      pick_q;
	logic [SIZE_BITS-1:0]  best_q;
	logic [SIZE_BITS-1:0]  wst_q;

	logic [CNT_W-1:0]      n_act;
	logic [CNT_W-1:0]      k_inc;
	logic [IDX_W-1:0]      k_next;
	logic [SIZE_BITS-1:0]  cur_size;
	logic                  fit;
	logic                  better;
	logic                  take;
	logic [SUM_W-1:0]      sum_wide;
	logic [TOTAL_W-1:0]    sum_sat;

	// A partition count above the number of built partitions acts as the full set.
	always_comb begin
		n_act = (32'(pcount_q) > PARTS) ? CNT_W'(PARTS) : CNT_W'(pcount_q);
	end

	always_comb begin
		k_inc    = CNT_W'(k_q) + CNT_W'(1);
		k_next   = (k_inc == n_act) ? '0 : IDX_W'(k_inc);
		cur_size = size_q[k_q];
		fit      = !busy_q[k_q] && (cur_size >= req_q);
		case (policy_q)
			POL_BEST:  better = cur_size < best_q;
			POL_WORST: better = cur_size > best_q;
			default:   better = 1'b0;
		endcase
		take     = fit && (!found_q || better);
		sum_wide = SUM_W'(sum_q) + SUM_W'(wst_q);
		sum_sat  = (sum_wide > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(sum_wide);
	end

	assign status.skip      = kind_q || (n_act == '0);
	assign status.scan_last = (cnt_q + CNT_W'(1)) == n_act;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_FIRST;
			pcount_q <= PCOUNT_RST;
			for (int p = 0; p < PARTS; p++) begin
				size_q[p] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_POLICY:     policy_q <= policy_t'(cfg_data[POLICY_W-1:0]);
				CFG_PART_COUNT: pcount_q <= cfg_data[PCOUNT_W-1:0];
				default: ;
			endcase
			for (int p = 0; p < PARTS; p++) begin
				if ((p < SIZE_REGS) && (cfg_index == CFG_IDX_W'(int'(CFG_SIZE_0) + p))) begin
					size_q[p] <= SIZE_BITS'(cfg_data);
				end
			end
		end
	end

	// Scan and commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= '0;
			ptr_q       <= '0;
			sum_q       <= '0;
			kind_q      <= 1'b0;
			req_q       <= '0;
			found_q     <= 1'b0;
			pick_q      <= '0;
			best_q      <= '0;
			wst_q       <= '0;
			cnt_q       <= '0;
			k_q         <= '0;
			res_granted <= 1'b0;
			res_pnum    <= '0;
			res_waste   <= '0;
			res_total   <= '0;
		end else begin
			if (cmd.start) begin
				kind_q  <= req_kind;
				req_q   <= SIZE_BITS'(req_size);
				k_q     <= ((policy_q == POL_NEXT) && (CNT_W'(ptr_q) < n_act)) ? ptr_q : '0;
				cnt_q   <= '0;
				found_q <= 1'b0;
			end
			if (cmd.step) begin
				if (take) begin
					found_q <= 1'b1;
					pick_q  <= k_q;
					best_q  <= cur_size;
					wst_q   <= cur_size - req_q;
				end
				cnt_q <= cnt_q + CNT_W'(1);
				k_q   <= k_next;
			end
			if (cmd.commit) begin
				if (kind_q) begin
					busy_q      <= '0;
					sum_q       <= '0;
					ptr_q       <= '0;
					res_granted <= 1'b0;
					res_pnum    <= '0;
					res_waste   <= '0;
					res_total   <= '0;
				end else if (found_q) begin
					busy_q[pick_q] <= 1'b1;
					if (policy_q == POL_NEXT) begin
						ptr_q <= pick_q;
					end
					sum_q       <= sum_sat;
					res_granted <= 1'b1;
					res_pnum    <= PNUM_W'(PN_W'(pick_q) + PN_W'(1));
					res_waste   <= OUT_WASTE_W'(wst_q);
					res_total   <= sum_sat;
				end else begin
					res_granted <= 1'b0;
					res_pnum    <= '0;
					res_waste   <= '0;
					res_total   <= sum_q;
				end
			end
		end
	end

	a_grant_marks_one: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && !kind_q && found_q)
		|=> ($countones(busy_q) == $past($countones(busy_q)) + 1))
		else $error("grant did not mark exactly one free partition busy");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && kind_q) |=> ((busy_q == '0) && (sum_q == '0) && (ptr_q == '0)))
		else $error("clear request left state behind");

	a_total_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && !kind_q) |=> (sum_q >= $past(sum_q)))
		else $error("waste total decreased without a clear");

endmodule

// ----- hw/rtl/fpa_ctrl.sv -----
// ----------------------------------------------------------------------------
// fpa_ctrl
// Sequencer of the allocator: accepts one request, steps the scan and
// commits the result into the output register when that is free.
// ----------------------------------------------------------------------------
module fpa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  fpa_pkg::status_t  status,
	output fpa_pkg::cmd_t     cmd
);
	import fpa_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign s_tready   = (state_q == ST_IDLE);
	assign m_tvalid   = out_valid_q;
	assign slot_free  = !out_valid_q || m_tready;

	assign cmd.start  = s_tready && s_tvalid;
	assign cmd.step   = (state_q == ST_SCAN) && !status.skip;
	assign cmd.commit = (state_q == ST_COMMIT) && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (status.skip || status.scan_last) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_tvalid)
		else $error("committed result not presented");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !cmd.commit)
		else $error("result overwritten before it was taken");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> !s_tready)
		else $error("second request accepted during a scan");

endmodule
